// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ipv4_lpm_pkg.sv =====
package ipv4_lpm_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int LEN_W          = 6;
   localparam int NODE_COUNT_DEF = 1024;

   // request kinds carried on req_tuser
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   // result status carried on rsp_tuser
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== sv/ipv4_lpm_compressed_trie_core.sv =====
// IPv4 longest-prefix-match route table, path-compressed binary trie.
// Request channel (req_*): one beat per lookup (tuser=0) or insert (tuser=1).
// Result channel (rsp_*): exactly one beat per request, in request order.
// A lookup walks the trie from the root, visiting at most 33 nodes; at each
// node visited it does one node store read, then one match step. An insert
// walks the same way; when a node must be split it then counts the common
// bits, one compared bit per cycle (up to 32). An insert that is not refused
// writes one to four entries of the node store, one entry a cycle through
// its single write port, and then hands off the result.
// The block takes one request at a time; req_tready is high only while no
// walk is in progress, and is high again in the same cycle that the result
// enters the output register. With the result held there, the next request
// is taken while rsp_tvalid waits on a stalled receiver; a second result
// then waits in the sequencer until the register frees up.
// Reset empties the table: the root reads as zero, one node in use, no
// clearing pass. When the store is full, an insert that needs new nodes is
// refused with status 1 and the table is left unchanged.
`include "assert_macros.svh"

module ipv4_lpm_compressed_trie_core #(
   parameter int NODE_COUNT = ipv4_lpm_pkg::NODE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // address[31:0], pfx_length[37:32], route_hop[69:38], zero
   input  logic [0:0]  req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // hop_out[31:0]
   output logic [1:0]  rsp_tuser    // found[0], status[1]
);

   localparam int IW   = $clog2(NODE_COUNT);
   localparam int NU_W = $clog2(NODE_COUNT + 1);
   localparam int AB   = ipv4_lpm_pkg::ADDR_BITS;
   localparam int LW   = ipv4_lpm_pkg::LEN_W;

   typedef struct packed {
      logic [AB-1:0] bits;
      logic [LW-1:0] len;
      logic          route;
      logic [31:0]   hop;
      logic [IW-1:0] c0;
      logic [IW-1:0] c1;
   } node_type;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_READ      = 12'b000000000010,
      S_NODE      = 12'b000000000100,
      S_COUNT     = 12'b000000001000,
      S_ROUTE_W   = 12'b000000010000,
      S_LEAF_N    = 12'b000000100000,
      S_LEAF_CUR  = 12'b000001000000,
      S_SPLIT_P   = 12'b000010000000,
      S_SPLIT_C   = 12'b000100000000,
      S_SPLIT_L   = 12'b001000000000,
      S_SPLIT_PAR = 12'b010000000000,
      S_DONE      = 12'b100000000000
   } state_type;

   localparam logic [LW-1:0] FULL_LEN = LW'(AB);

   state_type     state_ff, state_in;
   node_type      node_mem [NODE_COUNT];
   node_type      rd_ff;
   logic          rd_root_ff;
   logic          root_valid_ff, root_valid_in;
   node_type      rd_node;
   node_type      node_ff, node_in;
   node_type      par_ff, par_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] par_idx_ff, par_idx_in;
   logic [IW-1:0] new_idx_ff, new_idx_in;
   logic          side_ff, side_in;
   logic [AB-1:0] key_ff, key_in;
   logic [AB-1:0] diff_ff, diff_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] lim_ff, lim_in;
   logic          kind_ff, kind_in;
   logic [31:0]   rhop_ff, rhop_in;
   logic [NU_W-1:0] used_ff, used_in;
   logic          found_ff, found_in;
   logic [31:0]   hop_ff, hop_in;
   logic          status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [31:0]   rsp_hop_ff, rsp_hop_in;
   logic          rsp_status_ff, rsp_status_in;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   node_type      wr_data;

   // shared datapath terms
   logic [LW-1:0] rem;
   logic [LW-1:0] suf;
   logic [LW-1:0] nl_leaf;
   logic [LW-1:0] nl_split;
   logic [AB-1:0] top;
   logic [AB-1:0] key_sh;
   logic [LW-1:0] pos_sh;
   logic          compress;
   logic          fullm;
   logic [LW-1:0] pos_a;
   logic [AB-1:0] key_a;
   logic [IW-1:0] nxt;
   logic          full1;
   logic          full2;
   logic          term;
   logic          sbit;
   logic [IW-1:0] other;
   logic [NU_W:0] used_x;

   assign rd_node  = rd_root_ff ? '0 : rd_ff;
   assign rem      = plen_ff - pos_ff;
   assign suf      = node_ff.len - cnt_ff;
   assign nl_leaf  = plen_ff - pos_ff;
   assign nl_split = rem - cnt_ff;
   assign top      = key_ff >> (FULL_LEN - rd_node.len);
   assign key_sh   = key_ff << rd_node.len;
   assign pos_sh   = pos_ff + rd_node.len;
   assign compress = (rd_node.len != '0) && (cur_ff != '0);
   assign fullm    = (rd_node.len <= rem) && (top == rd_node.bits);
   assign pos_a    = compress ? pos_sh : pos_ff;
   assign key_a    = compress ? key_sh : key_ff;
   assign used_x   = {1'b0, used_ff};
   assign full1    = (used_x + (NU_W+1)'(1)) > (NU_W+1)'(NODE_COUNT);
   assign full2    = (used_x + (NU_W+1)'(2)) > (NU_W+1)'(NODE_COUNT);
   assign term     = (cnt_ff == rem);
   assign sbit     = node_ff.bits[5'(suf - LW'(1))];
   assign other    = term ? '0 : IW'(used_ff + NU_W'(1));

   // next child along the path, chosen by the leading key bit
   always_comb begin
      if (kind_ff == ipv4_lpm_pkg::REQ_LOOKUP) begin
         nxt = key_sh[AB-1] ? rd_node.c1 : rd_node.c0;
      end else begin
         nxt = key_a[AB-1] ? rd_node.c1 : rd_node.c0;
      end
   end

   // node store: one write port, one registered read at the current node
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_ff      <= node_mem[cur_ff];
      rd_root_ff <= (cur_ff == '0) && !root_valid_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      root_valid_in = root_valid_ff;
      node_in       = node_ff;
      par_in        = par_ff;
      cur_in        = cur_ff;
      par_idx_in    = par_idx_ff;
      new_idx_in    = new_idx_ff;
      side_in       = side_ff;
      key_in        = key_ff;
      diff_in       = diff_ff;
      pos_in        = pos_ff;
      plen_in       = plen_ff;
      cnt_in        = cnt_ff;
      lim_in        = lim_ff;
      kind_in       = kind_ff;
      rhop_in       = rhop_ff;
      used_in       = used_ff;
      found_in      = found_ff;
      hop_in        = hop_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = node_ff;
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            // take a request and start at the root
            if (req_tvalid) begin
               kind_in    = req_tuser[0];
               key_in     = req_tdata[31:0];
               plen_in    = (req_tdata[37:32] > FULL_LEN) ? FULL_LEN : req_tdata[37:32];
               rhop_in    = req_tdata[69:38];
               pos_in     = '0;
               cur_in     = '0;
               par_idx_in = '0;
               side_in    = 1'b0;
               found_in   = 1'b0;
               hop_in     = '0;
               status_in  = ipv4_lpm_pkg::STATUS_DONE;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            state_in = S_NODE;
         end
         S_NODE: begin
            node_in = rd_node;
            if (kind_ff == ipv4_lpm_pkg::REQ_LOOKUP) begin
               // match skipped bits, note any route, descend
               if (rd_node.len != '0 && top != rd_node.bits) begin
                  state_in = S_DONE;
               end else begin
                  key_in = key_sh;
                  pos_in = pos_sh;
                  if (rd_node.route) begin
                     found_in = 1'b1;
                     hop_in   = rd_node.hop;
                  end
                  if (pos_sh == FULL_LEN || nxt == '0) begin
                     state_in = S_DONE;
                  end else begin
                     cur_in   = nxt;
                     state_in = S_READ;
                  end
               end
            end else if (compress && !fullm) begin
               // partial match: count common bits one per cycle
               diff_in  = (rd_node.bits << (FULL_LEN - rd_node.len)) ^ key_ff;
               cnt_in   = '0;
               lim_in   = (rd_node.len < rem) ? rd_node.len : rem;
               state_in = S_COUNT;
            end else begin
               key_in = key_a;
               pos_in = pos_a;
               if (pos_a == plen_ff) begin
                  state_in = S_ROUTE_W;
               end else if (nxt == '0) begin
                  if (full1) begin
                     status_in = ipv4_lpm_pkg::STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_LEAF_N;
                  end
               end else begin
                  par_in     = rd_node;
                  par_idx_in = cur_ff;
                  side_in    = key_a[AB-1];
                  cur_in     = nxt;
                  state_in   = S_READ;
               end
            end
         end
         S_COUNT: begin
            if (cnt_ff < lim_ff && !diff_ff[AB-1]) begin
               cnt_in  = cnt_ff + LW'(1);
               diff_in = diff_ff << 1;
               key_in  = key_ff << 1;
            end else if (term ? full1 : full2) begin
               status_in = ipv4_lpm_pkg::STATUS_FULL;
               state_in  = S_DONE;
            end else begin
               state_in = S_SPLIT_P;
            end
         end
         S_ROUTE_W: begin
            // exact match: mark route, overwrite hop
            wr_en         = 1'b1;
            wr_data.route = 1'b1;
            wr_data.hop   = rhop_ff;
            state_in      = S_DONE;
         end
         S_LEAF_N: begin
            wr_en      = 1'b1;
            wr_addr    = IW'(used_ff);
            wr_data    = '{bits: key_ff >> (FULL_LEN - nl_leaf), len: nl_leaf, route: 1'b1,
                           hop: rhop_ff, c0: '0, c1: '0};
            new_idx_in = IW'(used_ff);
            used_in    = used_ff + NU_W'(1);
            state_in   = S_LEAF_CUR;
         end
         S_LEAF_CUR: begin
            // hang the new leaf under the current node
            wr_en = 1'b1;
            if (key_ff[AB-1]) begin
               wr_data.c1 = new_idx_ff;
            end else begin
               wr_data.c0 = new_idx_ff;
            end
            state_in = S_DONE;
         end
         S_SPLIT_P: begin
            // new parent takes the common head of the node
            wr_en      = 1'b1;
            wr_addr    = IW'(used_ff);
            wr_data    = '{bits: node_ff.bits >> suf, len: cnt_ff, route: term,
                           hop: term ? rhop_ff : 32'd0,
                           c0: sbit ? other : cur_ff, c1: sbit ? cur_ff : other};
            new_idx_in = IW'(used_ff);
            used_in    = used_ff + NU_W'(1);
            state_in   = S_SPLIT_C;
         end
         S_SPLIT_C: begin
            // old node keeps only its tail
            wr_en        = 1'b1;
            wr_data.bits = node_ff.bits & ~({AB{1'b1}} << suf);
            wr_data.len  = suf;
            state_in     = term ? S_SPLIT_PAR : S_SPLIT_L;
         end
         S_SPLIT_L: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(used_ff);
            wr_data  = '{bits: key_ff >> (FULL_LEN - nl_split), len: nl_split, route: 1'b1,
                         hop: rhop_ff, c0: '0, c1: '0};
            used_in  = used_ff + NU_W'(1);
            state_in = S_SPLIT_PAR;
         end
         S_SPLIT_PAR: begin
            // repoint the grandparent at the new parent
            wr_en   = 1'b1;
            wr_addr = par_idx_ff;
            wr_data = par_ff;
            if (side_ff) begin
               wr_data.c1 = new_idx_ff;
            end else begin
               wr_data.c0 = new_idx_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_hop_in    = hop_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en && wr_addr == '0) begin
         root_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_valid_ff <= 1'b0;
         used_ff       <= NU_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_valid_ff <= root_valid_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      par_ff        <= par_in;
      cur_ff        <= cur_in;
      par_idx_ff    <= par_idx_in;
      new_idx_ff    <= new_idx_in;
      side_ff       <= side_in;
      key_ff        <= key_in;
      diff_ff       <= diff_in;
      pos_ff        <= pos_in;
      plen_ff       <= plen_in;
      cnt_ff        <= cnt_in;
      lim_ff        <= lim_in;
      kind_ff       <= kind_in;
      rhop_ff       <= rhop_in;
      found_ff      <= found_in;
      hop_ff        <= hop_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hop_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_found_ff};

   `ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1,
      used_ff <= NU_W'(NODE_COUNT), "node count past store size")
   `ASSERT_IMPLIES(a_refused_quiet, clock, reset, rsp_tvalid && rsp_tuser[1],
      !rsp_tuser[0] && rsp_tdata == 32'd0, "refused insert carries a hit")
   `ASSERT_IMPLIES(a_alloc_write, clock, reset, wr_en && {1'b0, wr_addr} >= used_ff,
      state_ff == S_LEAF_N || state_ff == S_SPLIT_P || state_ff == S_SPLIT_L,
      "write to a free entry outside allocation")
   `ASSERT_NEXT(a_accept_walk, clock, reset, req_tvalid && req_tready,
      state_ff == S_READ, "accepted beat did not start a walk")

endmodule

// ===== bench/tb_ipv4_lpm_compressed_trie_core.sv =====
module tb_ipv4_lpm_compressed_trie_core;

   localparam int TABLE_NODES = ipv4_lpm_pkg::NODE_COUNT_DEF;

   typedef struct packed {
      logic        found;
      logic [31:0] hop;
      logic        status;
   } lpm_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // address[31:0], pfx_length[37:32], route_hop[69:38], zero
   logic [0:0]  req_tuser;   // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // hop_out[31:0]
   logic [1:0]  rsp_tuser;   // found[0], status[1]

   // shadow route table
   logic [31:0] trie_bits  [TABLE_NODES];
   logic [5:0]  trie_len   [TABLE_NODES];
   logic        trie_route [TABLE_NODES];
   logic [31:0] trie_hop   [TABLE_NODES];
   int          trie_zero  [TABLE_NODES];
   int          trie_one   [TABLE_NODES];
   int          trie_used;

   lpm_result_type expected_q[$];
   int          mismatches;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;
   logic [31:0] known_prefix[$];
   logic [5:0]  known_len[$];

   ipv4_lpm_compressed_trie_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   // bit at position pos, 0 being the most significant
   function automatic logic addr_bit(logic [31:0] a, int pos);
      return a[31 - pos];
   endfunction

   function automatic logic [31:0] addr_field(logic [31:0] a, int pos, int n);
      logic [63:0] wide;
      if (n == 0) return 32'd0;
      wide = {32'd0, a} >> (32 - pos - n);
      return wide[31:0] & ((64'd1 << n) - 1);
   endfunction

   function automatic int alloc_node(logic [31:0] bits, int len, logic route,
                                     logic [31:0] hop);
      int n;
      n = trie_used;
      trie_used++;
      trie_bits[n] = bits;
      trie_len[n] = len[5:0];
      trie_route[n] = route;
      trie_hop[n] = hop;
      trie_zero[n] = 0;
      trie_one[n] = 0;
      return n;
   endfunction

   function automatic void link_child(int node, logic side, int target);
      if (side) trie_one[node] = target;
      else trie_zero[node] = target;
   endfunction

   function automatic lpm_result_type match_longest(logic [31:0] a);
      lpm_result_type r;
      int cur, pos, len, nxt;
      r = '0;
      cur = 0;
      pos = 0;
      for (int s = 0; s < 34; s++) begin
         len = trie_len[cur];
         if (len > 0) begin
            if (len > 32 - pos) break;
            if (addr_field(a, pos, len) != trie_bits[cur]) break;
            pos += len;
         end
         if (trie_route[cur]) begin
            r.found = 1'b1;
            r.hop = trie_hop[cur];
         end
         if (pos >= 32) break;
         nxt = addr_bit(a, pos) ? trie_one[cur] : trie_zero[cur];
         if (nxt == 0) break;
         cur = nxt;
      end
      return r;
   endfunction

   // returns the status code of the insert
   function automatic logic add_route(logic [31:0] a, int plen, logic [31:0] hop);
      int cur, pos, par, len, rem, lim, c, nxt, nl, p, suf, leaf;
      logic side, b;
      cur = 0; pos = 0; par = 0; side = 1'b0;
      if (plen > 32) plen = 32;
      for (int s = 0; s < 34; s++) begin
         len = trie_len[cur];
         rem = plen - pos;
         if (len > 0 && cur != 0) begin
            lim = len < rem ? len : rem;
            c = 0;
            while (c < lim && trie_bits[cur][len - 1 - c] == addr_bit(a, pos + c)) c++;
            if (c < len) begin
               if (trie_used + ((c == rem) ? 1 : 2) > TABLE_NODES)
                  return ipv4_lpm_pkg::STATUS_FULL;
               p = alloc_node(32'({32'd0, trie_bits[cur]} >> (len - c)), c, 1'b0, 32'd0);
               suf = len - c;
               trie_bits[cur] = trie_bits[cur] & 32'((64'd1 << suf) - 1);
               trie_len[cur] = suf[5:0];
               link_child(p, trie_bits[cur][suf - 1], cur);
               if (c == rem) begin
                  trie_route[p] = 1'b1;
                  trie_hop[p] = hop;
               end else begin
                  nl = rem - c;
                  leaf = alloc_node(addr_field(a, pos + c, nl), nl, 1'b1, hop);
                  link_child(p, addr_bit(a, pos + c), leaf);
               end
               link_child(par, side, p);
               return ipv4_lpm_pkg::STATUS_DONE;
            end
            pos += len;
         end
         if (pos == plen) begin
            trie_route[cur] = 1'b1;
            trie_hop[cur] = hop;
            return ipv4_lpm_pkg::STATUS_DONE;
         end
         b = addr_bit(a, pos);
         nxt = b ? trie_one[cur] : trie_zero[cur];
         if (nxt == 0) begin
            if (trie_used + 1 > TABLE_NODES) return ipv4_lpm_pkg::STATUS_FULL;
            nl = plen - pos;
            leaf = alloc_node(addr_field(a, pos, nl), nl, 1'b1, hop);
            link_child(cur, b, leaf);
            return ipv4_lpm_pkg::STATUS_DONE;
         end
         par = cur;
         side = b;
         cur = nxt;
      end
      return ipv4_lpm_pkg::STATUS_DONE;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // offer one beat, predict on acceptance
   task automatic send_request(logic kind, logic [31:0] a, logic [5:0] plen,
                               logic [31:0] hop);
      lpm_result_type r;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, hop, plen, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = '0;
      if (kind == ipv4_lpm_pkg::REQ_LOOKUP) r = match_longest(a);
      else r.status = add_route(a, plen, hop);
      expected_q.push_back(r);
      if (kind == ipv4_lpm_pkg::REQ_INSERT && r.status == ipv4_lpm_pkg::STATUS_DONE &&
          known_prefix.size() < 400) begin
         known_prefix.push_back(a);
         known_len.push_back(plen);
      end
      @(negedge clock);
   endtask

   // receiver readiness, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      lpm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, 32'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tuser[0] !== want.found) report_mismatch("found", rsp_tuser[0], want.found);
            if (rsp_tdata !== want.hop) report_mismatch("hop", rsp_tdata, want.hop);
            if (rsp_tuser[1] !== want.status)
               report_mismatch("status", rsp_tuser[1], want.status);
         end
      end
   end

   // drop the request line and wait for every result
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // address that extends a known prefix with random host bits
   function automatic logic [31:0] near_address();
      int k;
      logic [31:0] m;
      if (known_prefix.size() == 0) return $urandom;
      k = $urandom_range(known_prefix.size() - 1);
      m = (known_len[k] >= 32) ? 32'hFFFF_FFFF :
          ~(32'hFFFF_FFFF >> known_len[k]);
      return (known_prefix[k] & m) | ($urandom & ~m);
   endfunction

   task automatic test_directed;
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h0A00_0001, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0000_0000, 6'd0, 32'hDEAD_BEEF);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0A00_0000, 6'd8, 32'h0000_000A);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0A01_0203, 6'd24, 32'h0000_0018);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0A01_FFFF, 6'd16, 32'h0000_0010);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0A80_0000, 6'd9, 32'h0000_0009);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'hFFFF_FFFE, 6'd63, 32'h1234_5678);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'hFFFF_0000, 6'd16, 32'h0000_FFFF);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0A00_0000, 6'd8, 32'h0000_00AA);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h8000_0000, 6'd1, 32'h8000_0001);
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0000_0000, 6'd32, 32'h5555_5555);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h0A01_0204, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h0A01_7777, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h0A80_0001, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'hFFFF_1234, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd63, 32'hFFFF_FFFF);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h8123_4567, 6'd0, 32'd0);
      send_request(ipv4_lpm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0, 32'd0);
   endtask

   task automatic test_random(int count);
      logic [31:0] a;
      logic [5:0]  plen;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         a = (pick < 60) ? near_address() : $urandom;
         plen = (pick % 10 == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
         if (pick < 45) send_request(ipv4_lpm_pkg::REQ_LOOKUP, a, 6'($urandom), $urandom);
         else send_request(ipv4_lpm_pkg::REQ_INSERT, a, plen, $urandom);
      end
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure;
      hold_off_cycles = 300;
      test_random(20);
   endtask

   // fill the store until inserts are refused, then check the table survives
   task automatic test_store_full;
      int refused;
      refused = 0;
      while (refused < 6) begin
         send_request(ipv4_lpm_pkg::REQ_INSERT, $urandom, 6'd32, $urandom);
         if (trie_used >= TABLE_NODES - 1) refused++;
      end
      send_request(ipv4_lpm_pkg::REQ_INSERT, 32'h0A00_0000, 6'd8, 32'h0BAD_F00D);
      test_random(30);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      mismatches = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      for (int i = 0; i < TABLE_NODES; i++) begin
         trie_bits[i] = '0; trie_len[i] = '0; trie_route[i] = 1'b0;
         trie_hop[i] = '0; trie_zero[i] = 0; trie_one[i] = 0;
      end
      trie_used = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(100);
      send_idle_pct = 83;
      test_random(60);
      send_idle_pct = 0;
      recv_stall_pct = 83;
      test_random(60);
      send_idle_pct = 12;
      recv_stall_pct = 12;
      test_random(60);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      test_store_full();

      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
